/* hdl/dds_pkg.sv */
package dds_pkg;

    localparam int WIDTH      = 32;
    localparam int VALUE_W    = 32;
    localparam int DIGIT_W    = 4;
    localparam int POS_W      = 4;
    localparam int MAX_DIGITS = 10;
    localparam int RADIX      = 10;
    localparam int PROD_W     = VALUE_W + 4;
    localparam int EFF_W      = (WIDTH < VALUE_W) ? WIDTH : VALUE_W;
    localparam logic [VALUE_W-1:0] VALUE_MASK =
        VALUE_W'((33'd1 << EFF_W) - 33'd1);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // [power][multiple] = multiple * 10**power
    typedef logic [MAX_DIGITS-1:0][RADIX-1:0][PROD_W-1:0] mul_tab_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   pos;
    } dds_entry_t;

    function automatic mul_tab_t build_mul_tab();
        mul_tab_t          tab;
        logic [PROD_W-1:0] p;
        p = PROD_W'(1);
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            for (int k = 0; k < RADIX; k++)
            begin
                tab[i][k] = PROD_W'(p * PROD_W'(k));
            end
            p = PROD_W'(p * PROD_W'(RADIX));
        end
        return tab;
    endfunction

    localparam mul_tab_t POW10_MUL = build_mul_tab();

endpackage

/* hdl/dds_if.sv */
interface dds_num_if;
    import dds_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface dds_dig_if;
    import dds_pkg::*;

    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit;
    logic               last_digit;

    modport source (output valid, output digit, output last_digit, input ready);
    modport sink (input valid, input digit, input last_digit, output ready);
endinterface

/* hdl/dds_front.sv */
module dds_front (
    dds_num_if.sink               numbers,
    output logic                  push_valid,
    input  logic                  push_ready,
    output dds_pkg::dds_entry_t   push_entry
);
    import dds_pkg::*;

    logic [VALUE_W-1:0] masked;
    logic [POS_W-1:0]   top_pos;

    // find the power of ten of the leading digit
    always_comb
    begin
        masked  = numbers.value & VALUE_MASK;
        top_pos = '0;
        for (int k = 1; k < MAX_DIGITS; k++)
        begin
            if ({4'b0, masked} >= POW10_MUL[k][1])
            begin
                top_pos = top_pos + POS_W'(1);
            end
        end
    end

    assign push_valid       = numbers.valid;
    assign numbers.ready    = push_ready;
    assign push_entry.value = masked;
    assign push_entry.pos   = top_pos;

endmodule

/* hdl/dds_queue.sv */
module dds_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  dds_pkg::dds_entry_t push_entry,
    output logic                pop_valid,
    input  logic                pop_ready,
    output dds_pkg::dds_entry_t pop_entry
);
    import dds_pkg::*;

    dds_entry_t          entries_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push, pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* hdl/dds_back.sv */
module dds_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  dds_pkg::dds_entry_t pop_entry,
    dds_dig_if.source           digits
);
    import dds_pkg::*;

    logic [VALUE_W-1:0] rem_reg, rem_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               busy_reg, busy_next;
    logic               valid_reg, valid_next;
    logic [DIGIT_W-1:0] digit_reg, digit_next;
    logic               last_reg, last_next;
    logic [DIGIT_W-1:0] q;
    logic [PROD_W-1:0]  sub;
    logic               fire;

    assign pop_ready         = !busy_reg;
    assign fire              = busy_reg && (!valid_reg || digits.ready);
    assign digits.valid      = valid_reg;
    assign digits.digit      = digit_reg;
    assign digits.last_digit = last_reg;

    // one digit per step: count multiples of the current power of ten
    always_comb
    begin
        q = '0;
        for (int k = 1; k < RADIX; k++)
        begin
            if ({4'b0, rem_reg} >= POW10_MUL[pos_reg][k])
            begin
                q = q + DIGIT_W'(1);
            end
        end
        sub = POW10_MUL[pos_reg][q];
    end

    always_comb
    begin
        rem_next   = rem_reg;
        pos_next   = pos_reg;
        busy_next  = busy_reg;
        valid_next = valid_reg;
        digit_next = digit_reg;
        last_next  = last_reg;
        if (valid_reg && digits.ready)
        begin
            valid_next = 1'b0;
        end
        if (fire)
        begin
            valid_next = 1'b1;
            digit_next = q;
            last_next  = (pos_reg == '0);
            rem_next   = rem_reg - sub[VALUE_W-1:0];
            if (pos_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg - POS_W'(1);
            end
        end
        else if (!busy_reg && pop_valid)
        begin
            rem_next  = pop_entry.value;
            pos_next  = pop_entry.pos;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        pos_reg   <= pos_next;
        digit_reg <= digit_next;
        last_reg  <= last_next;
    end

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> digit_reg <= DIGIT_W'(RADIX - 1))
        else $error("digit out of range");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && pos_reg == '0) |=> (!busy_reg && valid_reg && last_reg))
        else $error("run did not end on last digit");

    a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && pos_reg != '0) |=> (busy_reg && valid_reg && !last_reg))
        else $error("inner digit lost or marked last");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && pos_reg < POS_W'(MAX_DIGITS - 1))
        |-> {4'b0, rem_reg} < POW10_MUL[pos_reg + POS_W'(1)][1])
        else $error("remainder exceeds position");

endmodule

/* hdl/decimal_digit_splitter_top.sv */
// Decimal digit splitter: turns an unsigned binary number into its decimal
// digits, most significant first, without leading zeros.
// Channels: numbers (sink) carries value; digits (source) carries one digit
// per item with last_digit set on the least significant digit. Zero gives
// the single digit 0, marked last.
// Path: a number passes the queue and the digit unit to the output register.
// Throughput: a number of n digits (1 to 10) occupies the digit unit for a
// load step and one step per digit; the digit unit, which produces one digit
// per cycle while digits.ready is high, sets the rate.
// A two-entry queue between the classifier and the digit unit lets numbers
// be taken while earlier digits are still being sent.
// Reset: rst_n clears the queue, the digit unit and the output register;
// no item is pending afterwards.
// Stall: when digits.ready is low the current digit holds in the output
// register, the digit unit waits, and numbers.ready drops once the queue
// is full.
module decimal_digit_splitter_top (
    input  logic      clk,
    input  logic      rst_n,
    dds_num_if.sink   numbers,
    dds_dig_if.source digits
);
    import dds_pkg::*;

    logic       push_valid, push_ready;
    logic       pop_valid, pop_ready;
    dds_entry_t push_entry, pop_entry;

    dds_front u_front (
        .numbers    (numbers),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    dds_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    dds_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .digits    (digits)
    );

endmodule
